>>> rtl/core/dstq_pkg.sv
package dstq_pkg;

    // Defaults for the top-level parameters
    localparam int DSTQ_DEPTH      = 16;
    localparam int DSTQ_OWNER_BITS = 8;

    // Fixed field widths
    localparam int TIME_W     = 64;
    localparam int DELAY_W    = 32;
    localparam int OWNER_ID_W = 8;
    localparam int REQ_W      = 3;
    localparam int KIND_W     = 3;
    localparam int COUNT_W    = 5;
    localparam int GUARD_W    = 8;
    localparam int COUNT_MAX  = 31;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 80;

    localparam logic [GUARD_W-1:0] GUARD_RESET = 8'd2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ARM    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TIME   = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ARMED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEARED   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_TIME      = 3'd6;

    // Operation applied to every cell of the chain in the same cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_INSERT,
        OP_MARK_OWNER,
        OP_MARK_SEL,
        OP_COMPACT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [TIME_W-1:0]   key;
        logic [TIME_W-1:0]   cdl;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;
        logic mark;
        logic hole;
        logic le;
        logic hit_owner;
        logic hit_full;
    } cell_stat_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [OWNER_ID_W-1:0] owner;
        logic [TIME_W-1:0]     stamp;
        logic [COUNT_W-1:0]    count;
        logic                  last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_INC,
        ST_TICK_EMIT,
        ST_ARM_ADD,
        ST_ARM_GUARD,
        ST_ARM_INS,
        ST_CAN_SCAN,
        ST_CAN_RESP,
        ST_CLR_SCAN,
        ST_COMPACT,
        ST_CLR_RESP,
        ST_TIME_RESP
    } ctrl_state_t;

endpackage

>>> rtl/core/dstq_cell.sv
module dstq_cell
    import dstq_pkg::*;
#(
    parameter int OWNER_BITS = DSTQ_OWNER_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_cmd_t             cmd,
    input  logic [OWNER_BITS-1:0] cmd_owner,
    input  logic                  set_mark,
    input  logic                  lower_valid,
    input  logic                  lower_le,
    input  logic                  lower_hole,
    input  logic [TIME_W-1:0]     lower_deadline,
    input  logic [OWNER_BITS-1:0] lower_owner,
    input  logic                  upper_valid,
    input  logic                  upper_mark,
    input  logic [TIME_W-1:0]     upper_deadline,
    input  logic [OWNER_BITS-1:0] upper_owner,
    output cell_stat_t            stat,
    output logic [TIME_W-1:0]     deadline,
    output logic [OWNER_BITS-1:0] owner
);

    logic                  valid_reg, valid_next;
    logic                  mark_reg, mark_next;
    logic [TIME_W-1:0]     deadline_reg, deadline_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;

    // Local compares against the broadcast key and request
    always_comb
    begin
        stat.valid     = valid_reg;
        stat.mark      = mark_reg;
        stat.hole      = !(valid_reg && !mark_reg);
        stat.le        = valid_reg && (deadline_reg <= cmd.key);
        stat.hit_owner = valid_reg && (owner_reg == cmd_owner);
        stat.hit_full  = stat.hit_owner && (deadline_reg == cmd.cdl);
    end

    assign deadline = deadline_reg;
    assign owner    = owner_reg;

    // Pick next content from self, neighbors or the new entry
    always_comb
    begin
        valid_next    = valid_reg;
        mark_next     = mark_reg;
        deadline_next = deadline_reg;
        owner_next    = owner_reg;
        unique case (cmd.op)
            OP_SHIFT:
            begin
                valid_next    = upper_valid;
                mark_next     = 1'b0;
                deadline_next = upper_deadline;
                owner_next    = upper_owner;
            end
            OP_INSERT:
            begin
                if (!stat.le)
                begin
                    mark_next = 1'b0;
                    if (lower_le)
                    begin
                        valid_next    = 1'b1;
                        deadline_next = cmd.key;
                        owner_next    = cmd_owner;
                    end
                    else
                    begin
                        valid_next    = lower_valid;
                        deadline_next = lower_deadline;
                        owner_next    = lower_owner;
                    end
                end
            end
            OP_MARK_OWNER:
            begin
                mark_next = stat.hit_owner;
            end
            OP_MARK_SEL:
            begin
                mark_next = set_mark;
            end
            OP_COMPACT:
            begin
                if (stat.hole && upper_valid)
                begin
                    valid_next    = 1'b1;
                    mark_next     = upper_mark;
                    deadline_next = upper_deadline;
                    owner_next    = upper_owner;
                end
                else if (stat.hole || lower_hole)
                begin
                    // drop a marked entry, or release one the lower cell took
                    valid_next = 1'b0;
                    mark_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        owner_reg    <= owner_next;
    end

endmodule

>>> rtl/core/dstq_ctrl.sv
module dstq_ctrl
    import dstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DSTQ_DEPTH,
    parameter int OWNER_BITS  = DSTQ_OWNER_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [REQ_W-1:0]       in_req,
    input  logic [OWNER_ID_W-1:0]  in_owner,
    input  logic [DELAY_W-1:0]     in_delay,
    input  logic [TIME_W-1:0]      in_cdl,
    input  logic                   guard_we,
    input  logic [GUARD_W-1:0]     guard_wdata,
    input  cell_stat_t             stat [QUEUE_DEPTH],
    input  logic [TIME_W-1:0]      head_deadline,
    input  logic [OWNER_BITS-1:0]  head_owner,
    output cell_cmd_t              cmd,
    output logic [OWNER_BITS-1:0]  cmd_owner,
    output logic [QUEUE_DEPTH-1:0] set_mark,
    input  logic                   out_free,
    output logic                   res_load,
    output res_t                   res
);

    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_EXT_W = CNT_W + COUNT_W;

    ctrl_state_t            state_reg, state_next;
    logic [REQ_W-1:0]       req_reg, req_next;
    logic [OWNER_BITS-1:0]  owner_reg, owner_next;
    logic [DELAY_W-1:0]     delay_reg, delay_next;
    logic [TIME_W-1:0]      cdl_reg, cdl_next;
    logic [TIME_W-1:0]      tick_reg, tick_next;
    logic [GUARD_W-1:0]     guard_reg, guard_next;
    logic [TIME_W-1:0]      sum_reg, sum_next;
    logic [QUEUE_DEPTH-1:0] hit_vec_reg, hit_vec_next;
    logic [QUEUE_DEPTH-1:0] cnt_vec_reg, cnt_vec_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [QUEUE_DEPTH-1:0] busy_vec;
    logic [QUEUE_DEPTH-1:0] owner_hits;
    logic [QUEUE_DEPTH-1:0] full_hits;
    logic                   busy;
    logic                   full;
    logic                   any_hit;
    logic                   count_done;
    logic [TIME_W:0]        add_delay;
    logic [TIME_W:0]        add_guard;
    logic [CNT_EXT_W-1:0]   cnt_ext;
    logic [COUNT_W-1:0]     cnt_sat;

    // Gather per-cell flags; a cell is busy while it holds a marked entry or a hole sits under a live entry
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            owner_hits[i] = stat[i].hit_owner;
            full_hits[i]  = stat[i].hit_full;
            if (i < QUEUE_DEPTH - 1)
            begin
                busy_vec[i] = (stat[i].valid && stat[i].mark) ||
                              (stat[i].hole && stat[(i + 1) % QUEUE_DEPTH].valid);
            end
            else
            begin
                busy_vec[i] = stat[i].valid && stat[i].mark;
            end
        end
    end

    assign busy       = |busy_vec;
    assign full       = stat[QUEUE_DEPTH-1].valid;
    assign any_hit    = |hit_vec_reg;
    assign count_done = (cnt_vec_reg == '0);

    // Select the first matching cell for cancel
    always_comb
    begin
        logic [QUEUE_DEPTH-1:0] below;
        below = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            below = hit_vec_reg & ((QUEUE_DEPTH'(1) << i) - QUEUE_DEPTH'(1));
            set_mark[i] = hit_vec_reg[i] && (below == '0);
        end
    end

    // Saturating deadline adds
    assign add_delay = (TIME_W + 1)'(tick_reg) + (TIME_W + 1)'(delay_reg);
    assign add_guard = (TIME_W + 1)'(sum_reg) + (TIME_W + 1)'(guard_reg);

    // Saturate removed count to the field
    assign cnt_ext = CNT_EXT_W'(cnt_reg);
    assign cnt_sat = (cnt_ext > CNT_EXT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                       : cnt_ext[COUNT_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_req)
                        REQ_TICK:   state_next = ST_TICK_INC;
                        REQ_ARM:    state_next = ST_ARM_ADD;
                        REQ_CANCEL: state_next = ST_CAN_SCAN;
                        REQ_CLEAR:  state_next = ST_CLR_SCAN;
                        REQ_TIME:   state_next = ST_TIME_RESP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK_INC:  state_next = ST_TICK_EMIT;
            ST_TICK_EMIT:
            begin
                if (!stat[0].le)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ARM_ADD:   state_next = ST_ARM_GUARD;
            ST_ARM_GUARD: state_next = ST_ARM_INS;
            ST_ARM_INS:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CAN_SCAN:  state_next = ST_CAN_RESP;
            ST_CAN_RESP:
            begin
                if (out_free)
                begin
                    state_next = any_hit ? ST_COMPACT : ST_IDLE;
                end
            end
            ST_CLR_SCAN:  state_next = ST_COMPACT;
            ST_COMPACT:
            begin
                if (!busy && count_done)
                begin
                    state_next = (req_reg == REQ_CLEAR) ? ST_CLR_RESP : ST_IDLE;
                end
            end
            ST_CLR_RESP, ST_TIME_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs: chain command and result word
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        cmd.op     = OP_HOLD;
        cmd.key    = (state_reg == ST_ARM_INS) ? sum_reg : tick_reg;
        cmd.cdl    = cdl_reg;
        cmd_owner  = owner_reg;
        res_load   = 1'b0;
        res.kind   = KIND_TIME;
        res.owner  = OWNER_ID_W'(owner_reg);
        res.stamp  = '0;
        res.count  = '0;
        res.last   = 1'b1;
        unique case (state_reg)
            ST_TICK_EMIT:
            begin
                res.kind  = KIND_EXPIRED;
                res.owner = OWNER_ID_W'(head_owner);
                res.stamp = head_deadline;
                res.last  = !stat[1].le;
                if (stat[0].le && out_free)
                begin
                    res_load = 1'b1;
                    cmd.op   = OP_SHIFT;
                end
            end
            ST_ARM_INS:
            begin
                res_load = out_free;
                if (full)
                begin
                    res.kind = KIND_REJECTED;
                end
                else
                begin
                    res.kind  = KIND_ARMED;
                    res.stamp = sum_reg;
                    if (out_free)
                    begin
                        cmd.op = OP_INSERT;
                    end
                end
            end
            ST_CAN_RESP:
            begin
                res_load = out_free;
                if (any_hit)
                begin
                    res.kind  = KIND_CANCELLED;
                    res.stamp = cdl_reg;
                    if (out_free)
                    begin
                        cmd.op = OP_MARK_SEL;
                    end
                end
                else
                begin
                    res.kind = KIND_NOT_FOUND;
                end
            end
            ST_CLR_SCAN:
            begin
                cmd.op = OP_MARK_OWNER;
            end
            ST_COMPACT:
            begin
                cmd.op = OP_COMPACT;
            end
            ST_CLR_RESP:
            begin
                res_load  = out_free;
                res.kind  = KIND_CLEARED;
                res.count = cnt_sat;
            end
            ST_TIME_RESP:
            begin
                res_load  = out_free;
                res.kind  = KIND_TIME;
                res.owner = '0;
                res.stamp = tick_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath registers
    always_comb
    begin
        req_next     = req_reg;
        owner_next   = owner_reg;
        delay_next   = delay_reg;
        cdl_next     = cdl_reg;
        tick_next    = tick_reg;
        guard_next   = guard_we ? guard_wdata : guard_reg;
        sum_next     = sum_reg;
        hit_vec_next = hit_vec_reg;
        cnt_vec_next = cnt_vec_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = in_req;
                    owner_next   = OWNER_BITS'(in_owner);
                    delay_next   = in_delay;
                    cdl_next     = in_cdl;
                    cnt_vec_next = '0;
                    cnt_next     = '0;
                end
            end
            ST_TICK_INC:
            begin
                tick_next = tick_reg + TIME_W'(1);
            end
            ST_ARM_ADD:
            begin
                sum_next = add_delay[TIME_W] ? '1 : add_delay[TIME_W-1:0];
            end
            ST_ARM_GUARD:
            begin
                sum_next = add_guard[TIME_W] ? '1 : add_guard[TIME_W-1:0];
            end
            ST_CAN_SCAN:
            begin
                hit_vec_next = full_hits;
            end
            ST_CLR_SCAN:
            begin
                cnt_vec_next = owner_hits;
            end
            ST_COMPACT:
            begin
                // count one removed entry per cycle
                cnt_vec_next = cnt_vec_reg >> 1;
                cnt_next     = cnt_reg + CNT_W'(cnt_vec_reg[0]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tick_reg    <= '0;
            guard_reg   <= GUARD_RESET;
            cnt_vec_reg <= '0;
            cnt_reg     <= '0;
            hit_vec_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            guard_reg   <= guard_next;
            cnt_vec_reg <= cnt_vec_next;
            cnt_reg     <= cnt_next;
            hit_vec_reg <= hit_vec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        owner_reg <= owner_next;
        delay_reg <= delay_next;
        cdl_reg   <= cdl_next;
        sum_reg   <= sum_next;
    end

endmodule

>>> rtl/core/deadline_sorted_timer_queue.sv
// Deadline-sorted timer queue.
// Input stream s_*: one request word per handshake; s_tuser carries the request
// code (tick, arm, cancel, clear owner, read time), s_tdata the owner, delay and
// cancel deadline. Output stream m_*: result words; m_tuser carries the result
// kind and m_tlast marks the final word of a request. guard_ticks_we/wdata
// write the guard added to every armed deadline; write only while idle.
// One request is worked at a time; s_tready is high only when the queue is idle.
// Request steps: read time answers directly; arm adds the delay, then the guard,
// then inserts and answers; tick adds one to the time, then emits one word per
// expired entry; cancel scans, answers, then compacts; clear owner marks, compacts
// and answers with the count. Compaction ends when holes, moving up the cell chain
// one cell per cycle, are gone and the clear count, one hit bit per cycle, is done.
// A registered output stage holds each result word; while m_tready is low the
// queue stalls at its next word, and a finished request frees s_tready even
// if its word still waits. Reset empties the queue, zeroes the time counter
// and sets the guard to 2 ticks.
module deadline_sorted_timer_queue
    import dstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DSTQ_DEPTH,
    parameter int OWNER_BITS  = DSTQ_OWNER_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // owner_id[7:0], delay_ticks[39:8], cancel_deadline[103:40]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_owner[7:0], result_time[71:8], removed_count[76:72], zero[79:77]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_kind[2:0]
    output logic [KIND_W-1:0]     m_tuser,
    // last_result
    output logic                  m_tlast,
    input  logic                  guard_ticks_we,
    input  logic [GUARD_W-1:0]    guard_ticks_wdata
);

    cell_stat_t             stat     [QUEUE_DEPTH];
    logic [TIME_W-1:0]      deadline [QUEUE_DEPTH];
    logic [OWNER_BITS-1:0]  owner    [QUEUE_DEPTH];
    cell_cmd_t              cmd;
    logic [OWNER_BITS-1:0]  cmd_owner;
    logic [QUEUE_DEPTH-1:0] set_mark;
    logic                   out_free;
    logic                   res_load;
    res_t                   res;

    logic                   out_valid_reg, out_valid_next;
    res_t                   out_res_reg, out_res_next;

    dstq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .OWNER_BITS  (OWNER_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_req        (s_tuser),
        .in_owner      (s_tdata[7:0]),
        .in_delay      (s_tdata[39:8]),
        .in_cdl        (s_tdata[103:40]),
        .guard_we      (guard_ticks_we),
        .guard_wdata   (guard_ticks_wdata),
        .stat          (stat),
        .head_deadline (deadline[0]),
        .head_owner    (owner[0]),
        .cmd           (cmd),
        .cmd_owner     (cmd_owner),
        .set_mark      (set_mark),
        .out_free      (out_free),
        .res_load      (res_load),
        .res           (res)
    );

    // Cell chain, slot 0 is the earliest deadline
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                  lower_valid;
        logic                  lower_le;
        logic                  lower_hole;
        logic [TIME_W-1:0]     lower_deadline;
        logic [OWNER_BITS-1:0] lower_owner;
        logic                  upper_valid;
        logic                  upper_mark;
        logic [TIME_W-1:0]     upper_deadline;
        logic [OWNER_BITS-1:0] upper_owner;

        if (i == 0)
        begin : g_head
            assign lower_valid    = 1'b0;
            assign lower_le       = 1'b1;
            assign lower_hole     = 1'b0;
            assign lower_deadline = '0;
            assign lower_owner    = '0;
        end
        else
        begin : g_mid_low
            assign lower_valid    = stat[i-1].valid;
            assign lower_le       = stat[i-1].le;
            assign lower_hole     = stat[i-1].hole;
            assign lower_deadline = deadline[i-1];
            assign lower_owner    = owner[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign upper_valid    = 1'b0;
            assign upper_mark     = 1'b0;
            assign upper_deadline = '0;
            assign upper_owner    = '0;
        end
        else
        begin : g_mid_up
            assign upper_valid    = stat[i+1].valid;
            assign upper_mark     = stat[i+1].mark;
            assign upper_deadline = deadline[i+1];
            assign upper_owner    = owner[i+1];
        end

        dstq_cell #(
            .OWNER_BITS (OWNER_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .cmd_owner      (cmd_owner),
            .set_mark       (set_mark[i]),
            .lower_valid    (lower_valid),
            .lower_le       (lower_le),
            .lower_hole     (lower_hole),
            .lower_deadline (lower_deadline),
            .lower_owner    (lower_owner),
            .upper_valid    (upper_valid),
            .upper_mark     (upper_mark),
            .upper_deadline (upper_deadline),
            .upper_owner    (upper_owner),
            .stat           (stat[i]),
            .deadline       (deadline[i]),
            .owner          (owner[i])
        );
    end

    // Output stage: load a new word when empty or being taken
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;
    assign m_tdata  = {3'b000, out_res_reg.count, out_res_reg.stamp, out_res_reg.owner};

endmodule

>>> rtl/core/dstq_checker.sv
module dstq_checker
    import dstq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [REQ_W-1:0]      s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]     m_tuser,
    input logic                  m_tlast,
    input logic                  guard_ticks_we,
    input logic [GUARD_W-1:0]    guard_ticks_wdata
);

    // A stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Only expiry runs give more than one word
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_EXPIRED) |-> m_tlast)
        else $error("non-expiry result without last");

    // An unfinished expiry run keeps new requests out
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request accepted during expiry run");

    // A valid request leaves the idle state
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser <= REQ_TIME) |=> !s_tready)
        else $error("ready stayed high after a request");

    // Removed count only on clear results
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_CLEARED) |-> (m_tdata[76:72] == '0))
        else $error("removed count set on non-clear result");

endmodule

bind deadline_sorted_timer_queue dstq_checker u_dstq_checker (.*);
